// ===== rtl/vnbc_pkg.sv =====
// ----------------------------------------------------------------------------
// vnbc_pkg
// Types and constants shared by the nine-byte varint codec.
// ----------------------------------------------------------------------------
package vnbc_pkg;

	localparam int MAX_BYTES        = 9;
	localparam int QUEUE_DEPTH_DEF  = 2;
	localparam int CNT_W            = $clog2(MAX_BYTES + 1);

	localparam logic DIR_DECODE = 1'b0;
	localparam logic DIR_ENCODE = 1'b1;

	localparam logic [7:0] GROUP_MASK = 8'h7f;
	localparam logic [7:0] CONT_FLAG  = 8'h80;

	typedef struct packed {
		logic [7:0]  byte_in;
		logic [63:0] value_in;
		logic        end_of_buffer;
	} in_req_t;

	typedef struct packed {
		logic [63:0] value_out;
		logic [7:0]  byte_out;
		logic        last_byte;
		logic        error;
	} out_req_t;

	// queued job: a decoded value/error, or a pre-aligned value to emit as bytes
	typedef struct packed {
		logic             enc;
		logic [63:0]      data;
		logic [CNT_W-1:0] cnt;
		logic             err;
	} job_t;

endpackage

// ===== rtl/vnbc_front.sv =====
// ----------------------------------------------------------------------------
// vnbc_front
// Accepts requests; accumulates decode bytes, sizes and aligns encode values.
// ----------------------------------------------------------------------------
module vnbc_front import vnbc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_we,
	input  logic    cfg_wdata,
	input  logic    in_valid,
	output logic    in_ready,
	input  in_req_t in_req,
	output logic    job_valid,
	input  logic    job_ready,
	output job_t    job
);

	logic             direction_q;
	logic [63:0]      acc_q;
	logic [CNT_W-1:0] taken_q;

	logic             accept;
	logic [63:0]      acc_n;
	logic [CNT_W-1:0] taken_n;
	logic             done;
	logic             dec_emit;
	logic [7:0]       grp_nz;
	logic             nine;
	logic [CNT_W-1:0] nbytes;
	logic [63:0]      aligned;

	assign in_ready = job_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		if (taken_q >= CNT_W'(MAX_BYTES - 1)) begin
			acc_n   = {acc_q[55:0], in_req.byte_in};
			taken_n = taken_q;
			done    = 1'b1;
		end else begin
			acc_n   = {acc_q[56:0], in_req.byte_in[6:0]};
			taken_n = taken_q + CNT_W'(1);
			done    = (in_req.byte_in & CONT_FLAG) == 8'h00;
		end
		dec_emit = done || in_req.end_of_buffer;
	end

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			grp_nz[k] = |in_req.value_in[7*k +: 7];
		end
		nine   = |in_req.value_in[63:56];
		nbytes = CNT_W'(1);
		for (int k = 1; k < 8; k++) begin
			if (grp_nz[k]) nbytes = CNT_W'(k + 1);
		end
		if (nine) nbytes = CNT_W'(MAX_BYTES);
	end

	// top group lands in bits 63:57, ninth byte in bits 7:0
	always_comb begin
		case (nbytes)
			4'd1:    aligned = in_req.value_in << 57;
			4'd2:    aligned = in_req.value_in << 50;
			4'd3:    aligned = in_req.value_in << 43;
			4'd4:    aligned = in_req.value_in << 36;
			4'd5:    aligned = in_req.value_in << 29;
			4'd6:    aligned = in_req.value_in << 22;
			4'd7:    aligned = in_req.value_in << 15;
			4'd8:    aligned = in_req.value_in << 8;
			default: aligned = in_req.value_in;
		endcase
	end

	always_comb begin
		if (direction_q == DIR_ENCODE) begin
			job_valid = in_valid;
			job.enc   = 1'b1;
			job.data  = aligned;
			job.cnt   = nbytes;
			job.err   = 1'b0;
		end else begin
			job_valid = in_valid && dec_emit;
			job.enc   = 1'b0;
			job.data  = done ? acc_n : 64'd0;
			job.cnt   = CNT_W'(1);
			job.err   = !done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_DECODE;
		end else if (cfg_we) begin
			direction_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			taken_q <= '0;
		end else if (accept && direction_q == DIR_DECODE) begin
			if (dec_emit) begin
				acc_q   <= '0;
				taken_q <= '0;
			end else begin
				acc_q   <= acc_n;
				taken_q <= taken_n;
			end
		end
	end

endmodule

// ===== rtl/vnbc_queue.sv =====
// ----------------------------------------------------------------------------
// vnbc_queue
// Small job FIFO between the front and back sections.
// ----------------------------------------------------------------------------
module vnbc_queue import vnbc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_job
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);

	job_t              mem [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              push;
	logic              pop;

	assign push_ready = fill_q != FILL_W'(DEPTH);
	assign pop_valid  = fill_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_job    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + FILL_W'(1);
				2'b01:   fill_q <= fill_q - FILL_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(DEPTH))
		else $error("queue fill above depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == '0 |-> wr_ptr_q == rd_ptr_q)
		else $error("empty queue with pointers apart");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> fill_q == $past(fill_q) + FILL_W'(1))
		else $error("fill count missed a push");

endmodule

// ===== rtl/vnbc_back.sv =====
// ----------------------------------------------------------------------------
// vnbc_back
// Emits one result per decode job, one encode byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module vnbc_back import vnbc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     job_valid,
	output logic     job_ready,
	input  job_t     job,
	output logic     out_valid,
	input  logic     out_ready,
	output out_req_t out_req
);

	logic             cur_valid_q;
	logic             cur_enc_q;
	logic [63:0]      cur_data_q;
	logic [CNT_W-1:0] cur_rem_q;
	logic             cur_nine_q;
	logic             cur_err_q;
	logic             is_last;
	logic             step;

	assign is_last   = !cur_enc_q || cur_rem_q == CNT_W'(1);
	assign step      = cur_valid_q && out_ready;
	assign job_ready = !cur_valid_q || (step && is_last);
	assign out_valid = cur_valid_q;

	always_comb begin
		out_req = '0;
		if (cur_enc_q) begin
			out_req.last_byte = is_last;
			if (is_last && cur_nine_q) begin
				out_req.byte_out = cur_data_q[63:56];
			end else if (is_last) begin
				out_req.byte_out = {1'b0, cur_data_q[63:57]} & GROUP_MASK;
			end else begin
				out_req.byte_out = {1'b0, cur_data_q[63:57]} | CONT_FLAG;
			end
		end else begin
			out_req.value_out = cur_data_q;
			out_req.error     = cur_err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cur_enc_q   <= 1'b0;
			cur_rem_q   <= '0;
		end else if (job_ready) begin
			cur_valid_q <= job_valid;
			if (job_valid) begin
				cur_enc_q <= job.enc;
				cur_rem_q <= job.cnt;
			end
		end else if (step) begin
			cur_rem_q <= cur_rem_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready && job_valid) begin
			cur_data_q <= job.data;
			cur_nine_q <= job.cnt == CNT_W'(MAX_BYTES);
			cur_err_q  <= job.err;
		end else if (step) begin
			cur_data_q <= cur_data_q << 7;
		end
	end

	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q && cur_enc_q |-> cur_rem_q != '0 && cur_rem_q <= CNT_W'(MAX_BYTES))
		else $error("encode byte count out of range");

	a_no_pop_mid: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q && !is_last |-> !job_ready)
		else $error("job taken before varint finished");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_req))
		else $error("stalled result changed");

endmodule

// ===== rtl/varint_nine_byte_codec.sv =====
// ----------------------------------------------------------------------------
// varint_nine_byte_codec
// Big-endian base-128 varint codec, one to nine bytes per value.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we/cfg_wdata set direction (0 decode, 1 encode); write only when idle.
//   in_valid/in_ready/in_req carry one byte (decode) or one value (encode).
//   out_valid/out_ready/out_req carry results: a decoded value or error flag,
//   or encoded bytes, most significant group first, last_byte on the final.
// Timing:
//   A request is taken the cycle it arrives unless the job queue is full;
//   its first result is presented after the queue, then the output register.
//   Decode sustains one byte per cycle while the queue has room. Encode emits
//   one byte per cycle while out_ready is high, so a value holds the output
//   register until all its bytes (one to nine) are sent, and once the queue
//   fills, input is accepted only as values leave the output register.
// Reset:
//   Clears direction to decode, the partial varint, the queue and output.
// Stalls:
//   A result holds while out_ready is low; the queue absorbs QUEUE_DEPTH
//   further jobs before in_ready drops.
// ----------------------------------------------------------------------------
module varint_nine_byte_codec import vnbc_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     cfg_wdata,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_req_t  in_req,
	output logic     out_valid,
	input  logic     out_ready,
	output out_req_t out_req
);

	logic push_valid;
	logic push_ready;
	job_t push_job;
	logic pop_valid;
	logic pop_ready;
	job_t pop_job;

	vnbc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.job_valid (push_valid),
		.job_ready (push_ready),
		.job       (push_job)
	);

	vnbc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	vnbc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job_ready (pop_ready),
		.job       (pop_job),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_req   (out_req)
	);

endmodule
